[src/apu_pkg.sv]
// ----------------------------------------------------------------------------
// apu_pkg - shared types and round logic for the Ascon permutation unit
// Holds the state types, the mode codes, the command and status bundles
// between controller and datapath, and the single-round function.
// ----------------------------------------------------------------------------
package apu_pkg;

	typedef logic [63:0]       word_t;
	typedef logic [4:0][63:0]  perm_state_t;
	typedef logic [3:0]        round_idx_t;

	// round count selection
	typedef enum logic [1:0] {
		MODE_P12  = 2'd0,
		MODE_P8   = 2'd1,
		MODE_P6   = 2'd2,
		MODE_PASS = 2'd3
	} mode_t;

	localparam int unsigned ROUNDS_MAX = 12;
	localparam round_idx_t  FIRST_P12  = round_idx_t'(ROUNDS_MAX - 12);
	localparam round_idx_t  FIRST_P8   = round_idx_t'(ROUNDS_MAX - 8);
	localparam round_idx_t  FIRST_P6   = round_idx_t'(ROUNDS_MAX - 6);
	localparam round_idx_t  LAST_ROUND = round_idx_t'(ROUNDS_MAX - 1);

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture input transfer
		logic step;   // apply one round
		logic emit;   // move finished state to output register
	} apu_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pass;        // input mode applies no rounds
		logic last_round;  // current round is the final one
	} apu_status_t;

	function automatic word_t rotr(word_t x, int unsigned n);
		return (x >> n) | (x << (64 - n));
	endfunction

	// One Ascon round: constant addition, substitution layer, linear layer
	function automatic perm_state_t ascon_round(perm_state_t s, round_idx_t idx);
		word_t       a0, a1, a2, a3, a4;
		word_t       b0, b1, b2, b3, b4;
		perm_state_t r;
		a0 = s[0];
		a1 = s[1];
		a2 = s[2] ^ {56'd0, ~idx, idx};
		a3 = s[3];
		a4 = s[4];

		a0 = a0 ^ a4;
		a4 = a4 ^ a3;
		a2 = a2 ^ a1;

		b0 = a0 ^ (~a1 & a2);
		b1 = a1 ^ (~a2 & a3);
		b2 = a2 ^ (~a3 & a4);
		b3 = a3 ^ (~a4 & a0);
		b4 = a4 ^ (~a0 & a1);

		b1 = b1 ^ b0;
		b0 = b0 ^ b4;
		b3 = b3 ^ b2;
		b2 = ~b2;

		r[0] = b0 ^ rotr(b0, 19) ^ rotr(b0, 28);
		r[1] = b1 ^ rotr(b1, 61) ^ rotr(b1, 39);
		r[2] = b2 ^ rotr(b2, 1)  ^ rotr(b2, 6);
		r[3] = b3 ^ rotr(b3, 10) ^ rotr(b3, 17);
		r[4] = b4 ^ rotr(b4, 7)  ^ rotr(b4, 41);
		return r;
	endfunction

endpackage

[src/apu_if.sv]
// ----------------------------------------------------------------------------
// apu_if - valid/ready channels of the Ascon permutation unit
// Input channel carries the mode and the state before permutation, output
// channel the state after permutation.
// ----------------------------------------------------------------------------
interface apu_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [63:0] in_word0;
	logic [63:0] in_word1;
	logic [63:0] in_word2;
	logic [63:0] in_word3;
	logic [63:0] in_word4;

	modport source (output valid, output mode, output in_word0, output in_word1,
		output in_word2, output in_word3, output in_word4, input ready);
	modport sink (input valid, input mode, input in_word0, input in_word1,
		input in_word2, input in_word3, input in_word4, output ready);
endinterface

interface apu_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_word0;
	logic [63:0] out_word1;
	logic [63:0] out_word2;
	logic [63:0] out_word3;
	logic [63:0] out_word4;

	modport source (output valid, output out_word0, output out_word1,
		output out_word2, output out_word3, output out_word4, input ready);
	modport sink (input valid, input out_word0, input out_word1,
		input out_word2, input out_word3, input out_word4, output ready);
endinterface

[src/ascon_permutation_unit.sv]
// ----------------------------------------------------------------------------
// ascon_permutation_unit - Ascon p12 / p8 / p6 permutation
// Permutes a 320-bit state by 12, 8 or 6 rounds, or passes it through.
//
//   channel  | direction | payload
//   ---------+-----------+------------------------------------------
//   in_ch    | sink      | mode, in_word0 .. in_word4
//   out_ch   | source    | out_word0 .. out_word4
//
// One round per cycle in a shared round unit: an item is loaded, stepped
// through its rounds (none for pass) and moved to the output register.
// One item is in work at a time; the next input transfer is taken as soon
// as the result is in the output register, which may still await its
// output transfer. A stalled output holds the block in its drain state.
// Reset clears the controller and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module ascon_permutation_unit import apu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	apu_in_if.sink    in_ch,
	apu_out_if.source out_ch
);

	apu_cmd_t    cmd;
	apu_status_t status;
	perm_state_t in_state;
	perm_state_t out_state;

	assign in_state = {in_ch.in_word4, in_ch.in_word3, in_ch.in_word2,
		in_ch.in_word1, in_ch.in_word0};

	apu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	apu_datapath u_datapath (
		.clk       (clk),
		.mode      (in_ch.mode),
		.in_state  (in_state),
		.cmd       (cmd),
		.status    (status),
		.out_state (out_state)
	);

	assign out_ch.out_word0 = out_state[0];
	assign out_ch.out_word1 = out_state[1];
	assign out_ch.out_word2 = out_state[2];
	assign out_ch.out_word3 = out_state[3];
	assign out_ch.out_word4 = out_state[4];

endmodule

[src/apu_ctrl.sv]
// ----------------------------------------------------------------------------
// apu_ctrl - sequencing controller of the Ascon permutation unit
// Runs the one-hot state machine that takes a transfer, steps the rounds
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module apu_ctrl import apu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  apu_status_t status,
	output apu_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        in_fire;
	logic        out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// datapath commands
	always_comb begin
		cmd.load = in_fire;
		cmd.step = (state_q == ST_RUN);
		cmd.emit = (state_q == ST_DRAIN) && out_free;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = status.pass ? ST_DRAIN : ST_RUN;
				end
			end
			ST_RUN: begin
				if (status.last_round) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// result held until the output transfer completes
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[src/apu_datapath.sv]
// ----------------------------------------------------------------------------
// apu_datapath - state register, round logic and output register
// One Ascon round per step command; round index counts up to the last
// round of the schedule.
// ----------------------------------------------------------------------------
module apu_datapath import apu_pkg::*; (
	input  logic        clk,
	input  logic [1:0]  mode,
	input  perm_state_t in_state,
	input  apu_cmd_t    cmd,
	output apu_status_t status,
	output perm_state_t out_state
);

	perm_state_t work_q;
	perm_state_t out_q;
	round_idx_t  round_q;
	round_idx_t  first_round;
	mode_t       mode_sel;

	assign mode_sel = mode_t'(mode);

	// first round of the schedule for each mode
	always_comb begin
		unique case (mode_sel)
			MODE_P12: first_round = FIRST_P12;
			MODE_P8:  first_round = FIRST_P8;
			MODE_P6:  first_round = FIRST_P6;
			default:  first_round = LAST_ROUND;
		endcase
	end

	always_comb begin
		status.pass       = (mode_sel == MODE_PASS);
		status.last_round = (round_q == LAST_ROUND);
	end

	// working state, round index and output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q  <= in_state;
			round_q <= first_round;
		end else if (cmd.step) begin
			work_q  <= ascon_round(work_q, round_q);
			round_q <= round_q + round_idx_t'(1);
		end
		if (cmd.emit) begin
			out_q <= work_q;
		end
	end

	assign out_state = out_q;

endmodule

[src/apu_checker.sv]
// ----------------------------------------------------------------------------
// apu_checker - port-level checks for the Ascon permutation unit
// Watches both channels of the top level; bound in below.
// ----------------------------------------------------------------------------
module apu_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         in_valid,
	input logic         in_ready,
	input logic         out_valid,
	input logic         out_ready,
	input logic [319:0] out_data
);

	// result stays offered until its transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped before transfer");

	// stalled result keeps its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("output data changed while stalled");

	// one item in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready after transfer");

	// a new result appears just as the unit returns to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result appeared while unit busy");

endmodule

bind ascon_permutation_unit apu_checker u_apu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  ({out_ch.out_word4, out_ch.out_word3, out_ch.out_word2,
		out_ch.out_word1, out_ch.out_word0})
);
